[rtl/core/tphm_pkg.sv]
// ---------------------------------------------------------------------------
// tphm_pkg
// Shared constants, fixed-point helpers and the pipeline term record for the
// triangle pair hypercube map.
// ---------------------------------------------------------------------------
package tphm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 17;
    localparam int PROD_W    = 2 * VAL_W;

    localparam logic [VAL_W-1:0] FX_ONE = VAL_W'(1) << FRAC_BITS;

    localparam logic [1:0] CMD_VERTEX = 2'd0;
    localparam logic [1:0] CMD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_IDENT  = 2'd2;

    typedef logic [VAL_W-1:0] fx_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] sx;
        fx_t        k;
        fx_t        a;
        fx_t        b;
        fx_t        c;
        fx_t        kk;
        fx_t        ka;
        fx_t        kb;
        fx_t        ac;
        fx_t        ab;
        fx_t        bc;
        fx_t        k_na;
        fx_t        pa;
        fx_t        qb;
        fx_t        k3;
        fx_t        kb_nc;
        fx_t        kbc;
        fx_t        k_nac;
        fx_t        k_ac;
        fx_t        ka_nb;
        fx_t        k_nab;
        fx_t        kab;
        fx_t        abc;
        fx_t        ka_nbc;
        fx_t        kp;
        fx_t        aq;
        fx_t        kaq;
        fx_t        jac_v;
        fx_t        k3a;
        fx_t        kab_nc;
        fx_t        kabc;
        fx_t        k_nabc;
        fx_t        kr;
        fx_t        k3aa;
    } terms_t;

    function automatic fx_t fx_mul(input fx_t x, input fx_t y);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(y);
        return prod[FRAC_BITS +: VAL_W];
    endfunction

    function automatic fx_t fx_inv(input fx_t x);
        return FX_ONE - x;
    endfunction

    function automatic fx_t fx_sat(input fx_t x);
        return (x > FX_ONE) ? FX_ONE : x;
    endfunction

endpackage

[rtl/core/triangle_pair_hypercube_map.sv]
// ---------------------------------------------------------------------------
// triangle_pair_hypercube_map
// Maps a point of the unit 4-cube to a pair of reference-triangle points
// and a Jacobian factor for singular quadrature over triangle pairs.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel item_valid / item_stall carries command, simplex, ksi,
//   eta_a, eta_b and eta_c; a transfer happens on a rising edge with valid
//   high and stall low. Output channel result_valid / result_stall carries
//   test_u, test_v, trial_u, trial_v, jac and bad_case in the same way.
//   Coordinates above 1.0 are saturated to 1.0 on entry.
//   A transferred point passes through stages s1 to s4 and the output
//   register before it is shown on result_valid. The five register stages
//   each hold one level of truncating 17 x 17 multiplies, the longest
//   product chain being the Jacobian k*k*k*a*a*b.
//   Throughput is one point per cycle with no stall on the output.
//   Each stage accepts new data whenever it is empty or its successor
//   moves, so bubbles close up and the input stays open while a result
//   waits until all five stages are full. A stall on the output backs up
//   stage by stage; nothing is lost or repeated.
//   Reset empties all stages and clears result_valid.
// ---------------------------------------------------------------------------
module triangle_pair_hypercube_map
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [1:0]                command,
    input  logic [2:0]                simplex,
    input  logic [tphm_pkg::VAL_W-1:0] ksi,
    input  logic [tphm_pkg::VAL_W-1:0] eta_a,
    input  logic [tphm_pkg::VAL_W-1:0] eta_b,
    input  logic [tphm_pkg::VAL_W-1:0] eta_c,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [tphm_pkg::VAL_W-1:0] test_u,
    output logic [tphm_pkg::VAL_W-1:0] test_v,
    output logic [tphm_pkg::VAL_W-1:0] trial_u,
    output logic [tphm_pkg::VAL_W-1:0] trial_v,
    output logic [tphm_pkg::VAL_W-1:0] jac,
    output logic                      bad_case
);

    tphm_pkg::terms_t s1_reg, s1_next;
    tphm_pkg::terms_t s2_reg, s2_next;
    tphm_pkg::terms_t s3_reg, s3_next;
    tphm_pkg::terms_t s4_reg, s4_next;
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic             rdy1, rdy2, rdy3, rdy4, rdy5;

    logic             out_valid_reg;
    tphm_pkg::fx_t    xu_reg, xv_reg, yu_reg, yv_reg, jac_reg;
    tphm_pkg::fx_t    xu_next, xv_next, yu_next, yv_next, jac_next;
    logic             bad_reg, bad_next;
    tphm_pkg::fx_t    jac_ab;

    assign rdy5       = !out_valid_reg || !result_stall;
    assign rdy4       = !v4_reg || rdy5;
    assign rdy3       = !v3_reg || rdy4;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign item_stall = !rdy1;

    always_comb
    begin
        s1_next      = '0;
        s1_next.cmd  = command;
        s1_next.sx   = simplex;
        s1_next.k    = tphm_pkg::fx_sat(ksi);
        s1_next.a    = tphm_pkg::fx_sat(eta_a);
        s1_next.b    = tphm_pkg::fx_sat(eta_b);
        s1_next.c    = tphm_pkg::fx_sat(eta_c);
        s1_next.kk   = tphm_pkg::fx_mul(s1_next.k, s1_next.k);
        s1_next.ka   = tphm_pkg::fx_mul(s1_next.k, s1_next.a);
        s1_next.kb   = tphm_pkg::fx_mul(s1_next.k, s1_next.b);
        s1_next.ac   = tphm_pkg::fx_mul(s1_next.a, s1_next.c);
        s1_next.ab   = tphm_pkg::fx_mul(s1_next.a, s1_next.b);
        s1_next.bc   = tphm_pkg::fx_mul(s1_next.b, s1_next.c);
        s1_next.k_na = tphm_pkg::fx_mul(s1_next.k, tphm_pkg::fx_inv(s1_next.a));
        s1_next.pa   = tphm_pkg::fx_mul(s1_next.a, tphm_pkg::fx_inv(s1_next.b));
        s1_next.qb   = tphm_pkg::fx_mul(s1_next.b, tphm_pkg::fx_inv(s1_next.c));
    end

    always_comb
    begin
        s2_next        = s1_reg;
        s2_next.k3     = tphm_pkg::fx_mul(s1_reg.kk, s1_reg.k);
        s2_next.kb_nc  = tphm_pkg::fx_mul(s1_reg.kb, tphm_pkg::fx_inv(s1_reg.c));
        s2_next.kbc    = tphm_pkg::fx_mul(s1_reg.kb, s1_reg.c);
        s2_next.k_nac  = tphm_pkg::fx_mul(s1_reg.k, tphm_pkg::fx_inv(s1_reg.ac));
        s2_next.k_ac   = tphm_pkg::fx_mul(s1_reg.k, s1_reg.ac);
        s2_next.ka_nb  = tphm_pkg::fx_mul(s1_reg.ka, tphm_pkg::fx_inv(s1_reg.b));
        s2_next.k_nab  = tphm_pkg::fx_mul(s1_reg.k, tphm_pkg::fx_inv(s1_reg.ab));
        s2_next.kab    = tphm_pkg::fx_mul(s1_reg.ka, s1_reg.b);
        s2_next.abc    = tphm_pkg::fx_mul(s1_reg.ab, s1_reg.c);
        s2_next.ka_nbc = tphm_pkg::fx_mul(s1_reg.ka, tphm_pkg::fx_inv(s1_reg.bc));
        s2_next.kp     = tphm_pkg::fx_mul(s1_reg.k, tphm_pkg::fx_inv(s1_reg.pa));
        s2_next.aq     = tphm_pkg::fx_mul(s1_reg.a, tphm_pkg::fx_inv(s1_reg.qb));
        s2_next.kaq    = tphm_pkg::fx_mul(s1_reg.ka, tphm_pkg::fx_inv(s1_reg.qb));
    end

    always_comb
    begin
        s3_next        = s2_reg;
        s3_next.jac_v  = tphm_pkg::fx_mul(s2_reg.k3, s2_reg.b);
        s3_next.k3a    = tphm_pkg::fx_mul(s2_reg.k3, s2_reg.a);
        s3_next.kab_nc = tphm_pkg::fx_mul(s2_reg.kab, tphm_pkg::fx_inv(s2_reg.c));
        s3_next.kabc   = tphm_pkg::fx_mul(s2_reg.kab, s2_reg.c);
        s3_next.k_nabc = tphm_pkg::fx_mul(s2_reg.k, tphm_pkg::fx_inv(s2_reg.abc));
        s3_next.kr     = tphm_pkg::fx_mul(s2_reg.k, tphm_pkg::fx_inv(s2_reg.aq));
    end

    always_comb
    begin
        s4_next      = s3_reg;
        s4_next.k3aa = tphm_pkg::fx_mul(s3_reg.k3a, s3_reg.a);
    end

    // select the sub-simplex terms and zero an invalid kind/index pair
    always_comb
    begin
        jac_ab   = tphm_pkg::fx_mul(s4_reg.k3aa, s4_reg.b);
        xu_next  = '0;
        xv_next  = '0;
        yu_next  = '0;
        yv_next  = '0;
        jac_next = '0;
        bad_next = 1'b0;
        case (s4_reg.cmd)
            tphm_pkg::CMD_VERTEX:
            begin
                jac_next = s4_reg.jac_v;
                case (s4_reg.sx)
                    3'd0:
                    begin
                        xu_next = s4_reg.k_na;
                        xv_next = s4_reg.ka;
                        yu_next = s4_reg.kb_nc;
                        yv_next = s4_reg.kbc;
                    end
                    3'd1:
                    begin
                        xu_next = s4_reg.kb_nc;
                        xv_next = s4_reg.kbc;
                        yu_next = s4_reg.k_na;
                        yv_next = s4_reg.ka;
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end
            tphm_pkg::CMD_EDGE:
            begin
                jac_next = jac_ab;
                case (s4_reg.sx)
                    3'd0:
                    begin
                        xu_next  = s4_reg.k_nac;
                        xv_next  = s4_reg.k_ac;
                        yu_next  = s4_reg.k_na;
                        yv_next  = s4_reg.ka_nb;
                        jac_next = s4_reg.k3aa;
                    end
                    3'd1:
                    begin
                        xu_next = s4_reg.k_na;
                        xv_next = s4_reg.ka;
                        yu_next = s4_reg.k_nab;
                        yv_next = s4_reg.kab_nc;
                    end
                    3'd2:
                    begin
                        xu_next = s4_reg.k_na;
                        xv_next = s4_reg.ka_nb;
                        yu_next = s4_reg.k_nabc;
                        yv_next = s4_reg.kabc;
                    end
                    3'd3:
                    begin
                        xu_next = s4_reg.k_nab;
                        xv_next = s4_reg.kab_nc;
                        yu_next = s4_reg.k_na;
                        yv_next = s4_reg.ka;
                    end
                    3'd4:
                    begin
                        xu_next = s4_reg.k_na;
                        xv_next = s4_reg.ka_nbc;
                        yu_next = s4_reg.k_nab;
                        yv_next = s4_reg.kab;
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end
            tphm_pkg::CMD_IDENT:
            begin
                jac_next = jac_ab;
                case (s4_reg.sx)
                    3'd0:
                    begin
                        xu_next = s4_reg.ka_nb;
                        xv_next = s4_reg.kp;
                        yu_next = s4_reg.ka_nbc;
                        yv_next = s4_reg.k_na;
                    end
                    3'd1:
                    begin
                        xu_next = s4_reg.ka_nbc;
                        xv_next = s4_reg.k_na;
                        yu_next = s4_reg.ka_nb;
                        yv_next = s4_reg.kp;
                    end
                    3'd2:
                    begin
                        xu_next = s4_reg.kr;
                        xv_next = s4_reg.kaq;
                        yu_next = s4_reg.k_na;
                        yv_next = s4_reg.ka_nb;
                    end
                    3'd3:
                    begin
                        xu_next = s4_reg.k_na;
                        xv_next = s4_reg.ka_nb;
                        yu_next = s4_reg.kr;
                        yv_next = s4_reg.kaq;
                    end
                    3'd4:
                    begin
                        xu_next = s4_reg.k_na;
                        xv_next = s4_reg.ka_nbc;
                        yu_next = s4_reg.kp;
                        yv_next = s4_reg.ka_nb;
                    end
                    3'd5:
                    begin
                        xu_next = s4_reg.kp;
                        xv_next = s4_reg.ka_nb;
                        yu_next = s4_reg.k_na;
                        yv_next = s4_reg.ka_nbc;
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase
        if (bad_next)
        begin
            xu_next  = '0;
            xv_next  = '0;
            yu_next  = '0;
            yv_next  = '0;
            jac_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= item_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && item_valid)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
        if (rdy4 && v3_reg)
        begin
            s4_reg <= s4_next;
        end
        if (rdy5 && v4_reg)
        begin
            xu_reg  <= xu_next;
            xv_reg  <= xv_next;
            yu_reg  <= yu_next;
            yv_reg  <= yv_next;
            jac_reg <= jac_next;
            bad_reg <= bad_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign test_u       = xu_reg;
    assign test_v       = xv_reg;
    assign trial_u      = yu_reg;
    assign trial_v      = yv_reg;
    assign jac          = jac_reg;
    assign bad_case     = bad_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bad_case |->
            test_u == '0 && test_v == '0 && trial_u == '0 && trial_v == '0 && jac == '0)
        else $error("invalid case with non-zero result");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a held result");

    a_jac_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> jac <= tphm_pkg::FX_ONE)
        else $error("jacobian above one");

    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> test_u <= tphm_pkg::FX_ONE && test_v <= tphm_pkg::FX_ONE &&
            trial_u <= tphm_pkg::FX_ONE && trial_v <= tphm_pkg::FX_ONE)
        else $error("coordinate above one");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - triangle_pair_hypercube_map
// Streams cube points through the map with random idling on both channels,
// a long output hold that backs up the pipeline, and a final full-rate run.
// Every result transfer is compared field by field with a truncating
// fixed-point model of the Duffy-type map held in this bench.
// ---------------------------------------------------------------------------
module tb;

    localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         MAX_REPORTS  = 40;

    typedef logic [63:0] wide_t;

    localparam wide_t UNIT = wide_t'(1) << tphm_pkg::FRAC_BITS;

    typedef struct {
        tphm_pkg::fx_t test_u;
        tphm_pkg::fx_t test_v;
        tphm_pkg::fx_t trial_u;
        tphm_pkg::fx_t trial_v;
        tphm_pkg::fx_t jac;
        logic          bad_case;
    } mapping_t;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_stall;
    logic [1:0]    command;
    logic [2:0]    simplex;
    tphm_pkg::fx_t ksi;
    tphm_pkg::fx_t eta_a;
    tphm_pkg::fx_t eta_b;
    tphm_pkg::fx_t eta_c;
    logic          result_valid;
    logic          result_stall;
    tphm_pkg::fx_t test_u;
    tphm_pkg::fx_t test_v;
    tphm_pkg::fx_t trial_u;
    tphm_pkg::fx_t trial_v;
    tphm_pkg::fx_t jac;
    logic          bad_case;

    mapping_t pending_maps[$];
    int       mismatches = 0;
    bit       tx_gaps    = 1'b1;
    bit       rx_stalls  = 1'b1;
    int       hold_request = 0;

    triangle_pair_hypercube_map dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .simplex      (simplex),
        .ksi          (ksi),
        .eta_a        (eta_a),
        .eta_b        (eta_b),
        .eta_c        (eta_c),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .test_u       (test_u),
        .test_v       (test_v),
        .trial_u      (trial_u),
        .trial_v      (trial_v),
        .jac          (jac),
        .bad_case     (bad_case)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic wide_t fmul(input wide_t x, input wide_t y);
        return (x * y) >> tphm_pkg::FRAC_BITS;
    endfunction

    function automatic wide_t clamp_unit(input tphm_pkg::fx_t x);
        return (x > tphm_pkg::FX_ONE) ? UNIT : wide_t'(x);
    endfunction

    function automatic int simplex_count(input logic [1:0] cmd);
        case (cmd)
            tphm_pkg::CMD_VERTEX: return 2;
            tphm_pkg::CMD_EDGE:   return 5;
            tphm_pkg::CMD_IDENT:  return 6;
            default:              return 0;
        endcase
    endfunction

    function automatic mapping_t map_point(input logic [1:0] cmd, input logic [2:0] sx,
                                           input tphm_pkg::fx_t k_in,
                                           input tphm_pkg::fx_t a_in,
                                           input tphm_pkg::fx_t b_in,
                                           input tphm_pkg::fx_t c_in);
        wide_t    k, a, b, c, k3, p, q, r;
        wide_t    xu, xv, yu, yv, jf;
        logic     bad;
        mapping_t res;
        k   = clamp_unit(k_in);
        a   = clamp_unit(a_in);
        b   = clamp_unit(b_in);
        c   = clamp_unit(c_in);
        xu  = 0;
        xv  = 0;
        yu  = 0;
        yv  = 0;
        jf  = 0;
        bad = 1'b0;
        k3  = fmul(fmul(k, k), k);
        case (cmd)
            tphm_pkg::CMD_VERTEX:
            begin
                jf = fmul(k3, b);
                case (sx)
                    3'd0:
                    begin
                        xu = fmul(k, UNIT - a);
                        xv = fmul(k, a);
                        yu = fmul(fmul(k, b), UNIT - c);
                        yv = fmul(fmul(k, b), c);
                    end
                    3'd1:
                    begin
                        xu = fmul(fmul(k, b), UNIT - c);
                        xv = fmul(fmul(k, b), c);
                        yu = fmul(k, UNIT - a);
                        yv = fmul(k, a);
                    end
                    default: bad = 1'b1;
                endcase
            end
            tphm_pkg::CMD_EDGE:
            begin
                jf = fmul(fmul(k3, a), a);
                case (sx)
                    3'd0:
                    begin
                        xu = fmul(k, UNIT - fmul(a, c));
                        xv = fmul(k, fmul(a, c));
                        yu = fmul(k, UNIT - a);
                        yv = fmul(fmul(k, a), UNIT - b);
                    end
                    3'd1:
                    begin
                        xu = fmul(k, UNIT - a);
                        xv = fmul(k, a);
                        yu = fmul(k, UNIT - fmul(a, b));
                        yv = fmul(fmul(fmul(k, a), b), UNIT - c);
                        jf = fmul(jf, b);
                    end
                    3'd2:
                    begin
                        xu = fmul(k, UNIT - a);
                        xv = fmul(fmul(k, a), UNIT - b);
                        yu = fmul(k, UNIT - fmul(fmul(a, b), c));
                        yv = fmul(fmul(fmul(k, a), b), c);
                        jf = fmul(jf, b);
                    end
                    3'd3:
                    begin
                        xu = fmul(k, UNIT - fmul(a, b));
                        xv = fmul(fmul(fmul(k, a), b), UNIT - c);
                        yu = fmul(k, UNIT - a);
                        yv = fmul(k, a);
                        jf = fmul(jf, b);
                    end
                    3'd4:
                    begin
                        xu = fmul(k, UNIT - a);
                        xv = fmul(fmul(k, a), UNIT - fmul(b, c));
                        yu = fmul(k, UNIT - fmul(a, b));
                        yv = fmul(fmul(k, a), b);
                        jf = fmul(jf, b);
                    end
                    default: bad = 1'b1;
                endcase
            end
            tphm_pkg::CMD_IDENT:
            begin
                p  = UNIT - fmul(a, UNIT - b);
                q  = UNIT - fmul(b, UNIT - c);
                r  = UNIT - fmul(a, q);
                jf = fmul(fmul(fmul(k3, a), a), b);
                case (sx)
                    3'd0:
                    begin
                        xu = fmul(fmul(k, a), UNIT - b);
                        xv = fmul(k, p);
                        yu = fmul(fmul(k, a), UNIT - fmul(b, c));
                        yv = fmul(k, UNIT - a);
                    end
                    3'd1:
                    begin
                        xu = fmul(fmul(k, a), UNIT - fmul(b, c));
                        xv = fmul(k, UNIT - a);
                        yu = fmul(fmul(k, a), UNIT - b);
                        yv = fmul(k, p);
                    end
                    3'd2:
                    begin
                        xu = fmul(k, r);
                        xv = fmul(fmul(k, a), q);
                        yu = fmul(k, UNIT - a);
                        yv = fmul(fmul(k, a), UNIT - b);
                    end
                    3'd3:
                    begin
                        xu = fmul(k, UNIT - a);
                        xv = fmul(fmul(k, a), UNIT - b);
                        yu = fmul(k, r);
                        yv = fmul(fmul(k, a), q);
                    end
                    3'd4:
                    begin
                        xu = fmul(k, UNIT - a);
                        xv = fmul(fmul(k, a), UNIT - fmul(b, c));
                        yu = fmul(k, p);
                        yv = fmul(fmul(k, a), UNIT - b);
                    end
                    3'd5:
                    begin
                        xu = fmul(k, p);
                        xv = fmul(fmul(k, a), UNIT - b);
                        yu = fmul(k, UNIT - a);
                        yv = fmul(fmul(k, a), UNIT - fmul(b, c));
                    end
                    default: bad = 1'b1;
                endcase
            end
            default: bad = 1'b1;
        endcase
        if (bad)
        begin
            xu = 0;
            xv = 0;
            yu = 0;
            yv = 0;
            jf = 0;
        end
        res.test_u   = tphm_pkg::fx_t'(xu);
        res.test_v   = tphm_pkg::fx_t'(xv);
        res.trial_u  = tphm_pkg::fx_t'(yu);
        res.trial_v  = tphm_pkg::fx_t'(yv);
        res.jac      = tphm_pkg::fx_t'(jf);
        res.bad_case = bad;
        return res;
    endfunction

    function automatic tphm_pkg::fx_t rand_coord();
        int pick;
        pick = $urandom_range(0, 15);
        case (pick)
            0:       return '0;
            1:       return tphm_pkg::FX_ONE;
            2:       return tphm_pkg::fx_t'($urandom_range(65537, 131071));
            default: return tphm_pkg::fx_t'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic offer_point(input logic [1:0] cmd, input logic [2:0] sx,
                               input tphm_pkg::fx_t k, input tphm_pkg::fx_t a,
                               input tphm_pkg::fx_t b, input tphm_pkg::fx_t c);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        simplex    <= sx;
        ksi        <= k;
        eta_a      <= a;
        eta_b      <= b;
        eta_c      <= c;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_maps.push_back(map_point(cmd, sx, k, a, b, c));
    endtask

    task automatic random_point();
        logic [1:0] cmd;
        logic [2:0] sx;
        if ($urandom_range(0, 6) == 0)
        begin
            cmd = 2'($urandom_range(0, 3));
            sx  = 3'($urandom_range(0, 7));
        end
        else
        begin
            cmd = 2'($urandom_range(0, 2));
            sx  = 3'($urandom_range(0, simplex_count(cmd) - 1));
        end
        offer_point(cmd, sx, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic wait_drain();
        item_valid <= 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        for (int i = 0; i < simplex_count(tphm_pkg::CMD_VERTEX); i++)
            offer_point(tphm_pkg::CMD_VERTEX, 3'(i),
                        17'h0C000, 17'h08000, 17'h04000, 17'h0A000);
        for (int i = 0; i < simplex_count(tphm_pkg::CMD_EDGE); i++)
            offer_point(tphm_pkg::CMD_EDGE, 3'(i),
                        17'h0E000, 17'h0A000, 17'h06000, 17'h03000);
        for (int i = 0; i < simplex_count(tphm_pkg::CMD_IDENT); i++)
            offer_point(tphm_pkg::CMD_IDENT, 3'(i),
                        17'h0F000, 17'h0B000, 17'h07000, 17'h05000);
        // invalid index per kind and the unknown kind
        offer_point(tphm_pkg::CMD_VERTEX, 3'd2, 17'h08000, 17'h08000, 17'h08000, 17'h08000);
        offer_point(tphm_pkg::CMD_VERTEX, 3'd7, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        offer_point(tphm_pkg::CMD_EDGE, 3'd5, 17'h0C000, 17'h04000, 17'h02000, 17'h01000);
        offer_point(tphm_pkg::CMD_IDENT, 3'd6, 17'h0C000, 17'h04000, 17'h02000, 17'h01000);
        offer_point(CMD_UNKNOWN, 3'd0, 17'h0C000, 17'h04000, 17'h02000, 17'h01000);
        // extremes and coordinates above one
        offer_point(tphm_pkg::CMD_IDENT, 3'd2, '0, '0, '0, '0);
        offer_point(tphm_pkg::CMD_EDGE, 3'd1, tphm_pkg::FX_ONE, tphm_pkg::FX_ONE,
                    tphm_pkg::FX_ONE, tphm_pkg::FX_ONE);
        offer_point(tphm_pkg::CMD_IDENT, 3'd5, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        offer_point(tphm_pkg::CMD_VERTEX, 3'd0, tphm_pkg::FX_ONE, 17'h10001, '0, 17'h1FFFF);
        offer_point(tphm_pkg::CMD_EDGE, 3'd3, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF);
    endtask

    task automatic test_random_stream();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        repeat (1000) random_point();
    endtask

    task automatic test_output_hold();
        tx_gaps      = 1'b0;
        rx_stalls    = 1'b0;
        hold_request = HOLD_CYCLES;
        while (!result_stall)
            @(posedge clk);
        repeat (60) random_point();
    endtask

    task automatic test_full_rate();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        repeat (820) random_point();
    endtask

    task automatic compare_field(input string name, input tphm_pkg::fx_t want_v,
                                 input tphm_pkg::fx_t got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        mapping_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_maps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result expected none actual transfer", $time);
            end
            else
            begin
                want = pending_maps.pop_front();
                compare_field("test_u", want.test_u, test_u);
                compare_field("test_v", want.test_v, test_v);
                compare_field("trial_u", want.trial_u, trial_u);
                compare_field("trial_v", want.trial_v, trial_v);
                compare_field("jac", want.jac, jac);
                compare_field("bad_case", tphm_pkg::fx_t'(want.bad_case),
                              tphm_pkg::fx_t'(bad_case));
            end
        end
    end

    initial
    begin
        forever
        begin
            if (hold_request != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else if (rx_stalls && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                if (rx_stalls)
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                else
                    @(posedge clk);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        command    <= tphm_pkg::CMD_VERTEX;
        simplex    <= '0;
        ksi        <= '0;
        eta_a      <= '0;
        eta_b      <= '0;
        eta_c      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        wait_drain();
        test_random_stream();
        wait_drain();
        test_output_hold();
        wait_drain();
        test_full_rate();
        wait_drain();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
